// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, quiet during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/annexb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annexb_pkg
// Word types and byte constants for the Annex B NAL unit scanner.
// ----------------------------------------------------------------------------
package annexb_pkg;

   localparam logic [7:0] START_BYTE = 8'h01;
   localparam logic [7:0] ZERO_BYTE  = 8'h00;
   localparam logic [7:0] SPS_HDR_A  = 8'h27;
   localparam logic [7:0] SPS_HDR_B  = 8'h67;
   localparam logic [7:0] PPS_HDR_A  = 8'h28;
   localparam logic [7:0] PPS_HDR_B  = 8'h68;

   localparam logic [1:0] PCLASS_OTHER = 2'd0;
   localparam logic [1:0] PCLASS_SPS   = 2'd1;
   localparam logic [1:0] PCLASS_PPS   = 2'd2;

   localparam int OUT_OFF_BITS = 24;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_word_type;

   typedef struct packed {
      logic [OUT_OFF_BITS-1:0] unit_start;
      logic [OUT_OFF_BITS-1:0] unit_length;
      logic [7:0]              header_byte;
      logic [4:0]              unit_type;
      logic [1:0]              param_class;
      logic                    truncated;
      logic                    offset_overflow;
   } rsp_word_type;

   typedef struct packed {
      logic         emit;
      rsp_word_type word;
   } step_out_type;

endpackage

// ===== rtl/annexb_step_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annexb_step_core
// Scanner state and the per-byte step: start code search, unit tracking and
// result formation for one stream byte.
// ----------------------------------------------------------------------------
module annexb_step_core import annexb_pkg::*; #(
   parameter int OFFSET_BITS = 24
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_word_type word,
   input  logic         end_on_zero_triple,
   output step_out_type step_out
);

   localparam int EXT_W = OFFSET_BITS + OUT_OFF_BITS;
   localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};
   localparam logic [OFFSET_BITS-1:0] OFF_ONE = {{(OFFSET_BITS-1){1'b0}}, 1'b1};
   localparam logic [OFFSET_BITS-1:0] OFF_TWO = {{(OFFSET_BITS-2){1'b0}}, 2'b10};

   logic                   in_unit_ff,       in_unit_in;
   logic [1:0]             zero_run_ff,      zero_run_in;
   logic [OFFSET_BITS-1:0] byte_offset_ff,   byte_offset_in;
   logic [OFFSET_BITS-1:0] open_start_ff,    open_start_in;
   logic [7:0]             open_header_ff,   open_header_in;
   logic                   header_seen_ff,   header_seen_in;
   logic                   overflow_seen_ff, overflow_seen_in;

   logic                   start_code, at_max, ovf_now, term, trunc_emit, hdr_upd;
   logic [7:0]             hdr_eff, hdr_out;
   logic                   seen_eff;
   logic [OFFSET_BITS-1:0] p_inc_sat, end_pos, len;
   logic [OFFSET_BITS:0]   diff;
   logic [EXT_W-1:0]       start_ext, len_ext;

   always_comb begin
      start_code = (word.data_byte == START_BYTE) && (zero_run_ff == 2'd2);
      at_max     = (byte_offset_ff == OFF_MAX);
      ovf_now    = overflow_seen_ff | at_max;
      p_inc_sat  = at_max ? OFF_MAX : byte_offset_ff + OFF_ONE;

      term = in_unit_ff && (start_code ||
             (end_on_zero_triple && (word.data_byte == ZERO_BYTE) && (zero_run_ff == 2'd2)));
      trunc_emit = word.last_byte && in_unit_ff && !term;

      // first byte of an open unit becomes its header
      hdr_upd  = in_unit_ff && !term && !header_seen_ff;
      hdr_eff  = hdr_upd ? word.data_byte : open_header_ff;
      seen_eff = header_seen_ff | hdr_upd;

      // terminator: unit ends before the two zeros; stream end: includes byte
      if (term) begin
         end_pos = (byte_offset_ff >= OFF_TWO) ? byte_offset_ff - OFF_TWO : '0;
      end else begin
         end_pos = p_inc_sat;
      end
      diff = {1'b0, end_pos} - {1'b0, open_start_ff};
      len  = (diff[OFFSET_BITS] || (diff == '0)) ? '0 : diff[OFFSET_BITS-1:0];

      hdr_out = ((len != '0) && seen_eff) ? hdr_eff : 8'h00;

      start_ext = {{OUT_OFF_BITS{1'b0}}, open_start_ff};
      len_ext   = {{OUT_OFF_BITS{1'b0}}, len};

      step_out.emit                 = term | trunc_emit;
      step_out.word.unit_start      = start_ext[OUT_OFF_BITS-1:0];
      step_out.word.unit_length     = len_ext[OUT_OFF_BITS-1:0];
      step_out.word.header_byte     = hdr_out;
      step_out.word.unit_type       = hdr_out[4:0];
      case (hdr_out)
         SPS_HDR_A, SPS_HDR_B: step_out.word.param_class = PCLASS_SPS;
         PPS_HDR_A, PPS_HDR_B: step_out.word.param_class = PCLASS_PPS;
         default:              step_out.word.param_class = PCLASS_OTHER;
      endcase
      step_out.word.truncated       = trunc_emit;
      step_out.word.offset_overflow = ovf_now;
   end

   always_comb begin
      if (word.last_byte) begin
         in_unit_in       = 1'b0;
         zero_run_in      = 2'd0;
         byte_offset_in   = '0;
         open_start_in    = '0;
         open_header_in   = 8'h00;
         header_seen_in   = 1'b0;
         overflow_seen_in = 1'b0;
      end else begin
         in_unit_in       = (in_unit_ff && !term) || start_code;
         if (word.data_byte == ZERO_BYTE) begin
            zero_run_in = (zero_run_ff == 2'd2) ? 2'd2 : zero_run_ff + 2'd1;
         end else begin
            zero_run_in = 2'd0;
         end
         byte_offset_in   = p_inc_sat;
         open_start_in    = start_code ? p_inc_sat : open_start_ff;
         open_header_in   = start_code ? 8'h00 : hdr_eff;
         header_seen_in   = start_code ? 1'b0 : seen_eff;
         overflow_seen_in = ovf_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_unit_ff       <= 1'b0;
         zero_run_ff      <= 2'd0;
         byte_offset_ff   <= '0;
         open_start_ff    <= '0;
         open_header_ff   <= 8'h00;
         header_seen_ff   <= 1'b0;
         overflow_seen_ff <= 1'b0;
      end else if (fire) begin
         in_unit_ff       <= in_unit_in;
         zero_run_ff      <= zero_run_in;
         byte_offset_ff   <= byte_offset_in;
         open_start_ff    <= open_start_in;
         open_header_ff   <= open_header_in;
         header_seen_ff   <= header_seen_in;
         overflow_seen_ff <= overflow_seen_in;
      end
   end

endmodule

// ===== rtl/annexb_nal_unit_scanner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annexb_nal_unit_scanner
// Annex B byte stream scanner: finds start codes, reports closed NAL units.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one stream byte per word, last_byte flags the final byte.
//   rsp_*  : one word per closed unit (start, length, header, type, class,
//            truncated and overflow flags). Most bytes produce no word.
//   csr_*  : end_on_zero_triple mode bit, write only while idle.
// A byte is registered on accept and processed in the next cycle in which the
// result register is free or draining; its result is registered at the end
// of that cycle, so rsp_valid rises at that edge when the byte closes a unit.
// Throughput is one byte per cycle while the receiver does not stall, limited
// by the single state update per byte in the step core.
// When the receiver stalls, the pending result holds in the output register
// and one more byte waits in the input register; req_ready then drops.
// Reset is synchronous: stream state clears, the mode bit returns to 1 and
// both registers empty. A last_byte word also clears stream state.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module annexb_nal_unit_scanner import annexb_pkg::*; #(
   parameter int OFFSET_BITS = 24
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data
);

   logic         in_valid_ff;
   req_word_type in_word_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_word_ff;
   logic         mode_ff;
   logic         advance;
   step_out_type step_out;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      if (advance) begin
         out_valid_in = step_out.emit;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= 1'b1;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_word_ff <= req_word;
      end
      if (advance && step_out.emit) begin
         out_word_ff <= step_out.word;
      end
   end

   annexb_step_core #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_core (
      .clock              (clock),
      .reset              (reset),
      .fire               (advance),
      .word               (in_word_ff),
      .end_on_zero_triple (mode_ff),
      .step_out           (step_out)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   `ASSERT_IMPLY(a_ready_when_empty, clock, reset, !in_valid_ff, req_ready)
   `ASSERT_NEXT(a_emit_shows, clock, reset, advance && step_out.emit, rsp_valid)
   `ASSERT_NEXT(a_in_hold, clock, reset, in_valid_ff && !advance,
                in_valid_ff && $stable(in_word_ff))
   `ASSERT_IMPLY(a_trunc_on_last, clock, reset, advance && step_out.word.truncated,
                 in_word_ff.last_byte)

endmodule
